### hdl/tis_pkg.sv
// Shared types and constants for the tile image scaler.
// No dependencies; every other file in the block but tis_ram imports this package.
`default_nettype none

package tis_pkg;

    localparam int STEP_W     = 17;
    localparam int IDX_W      = 8;
    localparam int DIVISOR_W  = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [STEP_W-1:0] STEP_RESET = 17'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH_MODE    = 3'd0,
        CFG_SOURCE_WIDTH  = 3'd1,
        CFG_SOURCE_HEIGHT = 3'd2,
        CFG_TARGET_WIDTH  = 3'd3,
        CFG_TARGET_HEIGHT = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [STEP_W-1:0] col_step;
        logic [STEP_W-1:0] row_step;
        logic [IDX_W-1:0]  last_col;
        logic [IDX_W-1:0]  last_row;
    } t_geom;

    typedef struct packed {
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic [31:0]      pixel;
        logic [7:0]       version;
    } t_load;

    typedef struct packed {
        logic             vld;
        logic             mode;
        t_load            ld;
        logic [IDX_W-1:0] r0;
        logic [IDX_W-1:0] r1;
        logic [IDX_W-1:0] c0;
        logic [IDX_W-1:0] c1;
    } t_req;

endpackage

`default_nettype wire

### hdl/tis_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tis_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/tis_divider.sv
// Restoring divider, one quotient bit per cycle, that also holds the step result.
// Depends on tis_pkg.
`default_nettype none

module tis_divider (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [tis_pkg::STEP_W-1:0]      i_dividend,
    input  wire logic [tis_pkg::DIVISOR_W-1:0]   i_divisor,
    output logic                                 o_busy,
    output logic      [tis_pkg::STEP_W-1:0]      o_quot
);
    import tis_pkg::*;

    localparam int CNT_W = $clog2(STEP_W + 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [STEP_W-1:0]    r_q;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_d;
    logic [DIVISOR_W:0]   n_trial;
    logic                 n_fit;

    always_comb begin
        n_trial = {r_rem, r_q[STEP_W-1]};
        n_fit   = (n_trial >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_q    <= STEP_RESET;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(STEP_W);
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_d    <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
            if (n_fit) begin
                r_rem <= DIVISOR_W'(n_trial - {1'b0, r_d});
                r_q   <= {r_q[STEP_W-2:0], 1'b1};
            end else begin
                r_rem <= DIVISOR_W'(n_trial);
                r_q   <= {r_q[STEP_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with an exhausted bit count");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_busy) && $past(i_rst_n)) |-> (r_rem < r_d))
        else $error("divider finished with a remainder not below the divisor");

endmodule

`default_nettype wire

### hdl/tis_pos.sv
// Position pipeline: destination coordinate, step multiply, half-step offset and
// saturation to source indices over four register stages. Depends on tis_pkg.
`default_nettype none

module tis_pos #(
    parameter int TILE_SIZE = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tis_pkg::t_geom i_geom,
    input  wire logic           i_start,
    input  wire logic           i_mode,
    input  wire tis_pkg::t_load i_load,
    input  wire logic [3:0]     i_tile_col,
    input  wire logic [3:0]     i_tile_row,
    input  wire logic [5:0]     i_offset_col,
    input  wire logic [5:0]     i_offset_row,
    output tis_pkg::t_req       o_req
);
    import tis_pkg::*;

    localparam int DW = $clog2(15 * TILE_SIZE + 64);
    localparam int PW = DW + STEP_W;
    localparam int QW = PW + 1;
    localparam int IW = QW - 8;

    function automatic logic [IDX_W-1:0] clamp_idx(input logic [QW-1:0] p,
                                                   input logic [IDX_W-1:0] last);
        logic [IW-1:0] idx;
        begin
            idx = p[QW-1:8];
            if (idx > IW'(last)) begin
                return last;
            end
            return idx[IDX_W-1:0];
        end
    endfunction

    logic          r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    logic          r_a_mode, r_b_mode, r_c_mode, r_d_mode;
    t_load         r_a_ld, r_b_ld, r_c_ld, r_d_ld;
    logic [DW-1:0] r_a_x, r_a_y;
    logic [PW-1:0] r_b_x, r_b_y;
    logic [PW-1:0] r_c_x0, r_c_y0;
    logic [QW-1:0] r_c_x1, r_c_y1;
    logic [IDX_W-1:0] r_d_c0, r_d_c1, r_d_r0, r_d_r1;
    logic [DW-1:0] n_a_x, n_a_y;

    always_comb begin
        n_a_x = DW'(DW'(i_tile_col) * DW'(TILE_SIZE)) + DW'(i_offset_col);
        n_a_y = DW'(DW'(i_tile_row) * DW'(TILE_SIZE)) + DW'(i_offset_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            r_a_vld <= i_start;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_mode <= i_mode;
        r_a_ld   <= i_load;
        r_a_x    <= n_a_x;
        r_a_y    <= n_a_y;

        r_b_mode <= r_a_mode;
        r_b_ld   <= r_a_ld;
        r_b_x    <= PW'(r_a_x) * PW'(i_geom.col_step);
        r_b_y    <= PW'(r_a_y) * PW'(i_geom.row_step);

        r_c_mode <= r_b_mode;
        r_c_ld   <= r_b_ld;
        r_c_x0   <= r_b_x;
        r_c_y0   <= r_b_y;
        r_c_x1   <= QW'(r_b_x) + QW'(i_geom.col_step >> 1);
        r_c_y1   <= QW'(r_b_y) + QW'(i_geom.row_step >> 1);

        r_d_mode <= r_c_mode;
        r_d_ld   <= r_c_ld;
        r_d_c0   <= clamp_idx(QW'(r_c_x0), i_geom.last_col);
        r_d_c1   <= clamp_idx(r_c_x1, i_geom.last_col);
        r_d_r0   <= clamp_idx(QW'(r_c_y0), i_geom.last_row);
        r_d_r1   <= clamp_idx(r_c_y1, i_geom.last_row);
    end

    always_comb begin
        o_req.vld  = r_d_vld;
        o_req.mode = r_d_mode;
        o_req.ld   = r_d_ld;
        o_req.r0   = r_d_r0;
        o_req.r1   = r_d_r1;
        o_req.c0   = r_d_c0;
        o_req.c1   = r_d_c1;
    end

    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld |-> (r_d_c0 <= $past(i_geom.last_col) && r_d_c1 <= $past(i_geom.last_col)
                     && r_d_r0 <= $past(i_geom.last_row)
                     && r_d_r1 <= $past(i_geom.last_row)))
        else $error("source index beyond the saturation limit");

endmodule

`default_nettype wire

### hdl/tis_blend.sv
// Blend pipeline: per-byte floor-average tree over four samples (or the low byte of
// s00 when depth mode is clear) and the output register. Depends on tis_pkg.
`default_nettype none

module tis_blend (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    input  wire logic        i_depth_mode,
    input  wire logic [31:0] i_s00,
    input  wire logic [31:0] i_s11,
    input  wire logic [31:0] i_s01,
    input  wire logic [31:0] i_s10,
    input  wire logic [7:0]  i_version,
    output logic             o_strobe,
    output logic      [31:0] o_pixel,
    output logic      [7:0]  o_version
);
    import tis_pkg::*;

    localparam logic [31:0] BYTE_MASK = 32'hfefe_fefe;

    function automatic logic [31:0] avg_bytes(input logic [31:0] a, input logic [31:0] b);
        return (((a ^ b) & BYTE_MASK) >> 1) + (a & b);
    endfunction

    logic        r_f_vld, r_g_vld;
    logic [31:0] r_f_a1, r_f_a2;
    logic [7:0]  r_f_low, r_f_ver;
    logic [31:0] r_g_pixel;
    logic [7:0]  r_g_ver;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else begin
            r_f_vld <= i_vld;
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_a1  <= avg_bytes(i_s00, i_s11);
        r_f_a2  <= avg_bytes(i_s01, i_s10);
        r_f_low <= i_s00[7:0];
        r_f_ver <= i_version;

        if (i_depth_mode) begin
            r_g_pixel <= avg_bytes(r_f_a1, r_f_a2);
        end else begin
            r_g_pixel <= {24'd0, r_f_low};
        end
        r_g_ver <= r_f_ver;
    end

    assign o_strobe  = r_g_vld;
    assign o_pixel   = r_g_pixel;
    assign o_version = r_g_ver;

endmodule

`default_nettype wire

### hdl/tile_image_scaler.sv
// Tile image scaler: words pass the position, store read and blend registers to the
// strobe. Throughput is one word per cycle while busy is low, set by the position and
// blend pipelines and the four replicated source stores. A defined register write holds
// busy while the step dividers run. Synchronous reset restores the register defaults,
// sets both steps to 256 and clears the row version valid bits; results are strobed.
`default_nettype none

module tile_image_scaler #(
    parameter int TILE_SIZE      = 64,
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_mode,
    input  wire logic [7:0]                       i_src_col,
    input  wire logic [7:0]                       i_src_row,
    input  wire logic [31:0]                      i_pixel_in,
    input  wire logic [7:0]                       i_row_version_in,
    input  wire logic [3:0]                       i_tile_col,
    input  wire logic [3:0]                       i_tile_row,
    input  wire logic [5:0]                       i_offset_col,
    input  wire logic [5:0]                       i_offset_row,
    output logic                                  o_strobe,
    output logic      [31:0]                      o_pixel_out,
    output logic      [7:0]                       o_row_version_out,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tis_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tis_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tis_pkg::*;

    localparam int STORE_DEPTH = 1 << (2 * IDX_W);
    localparam int ROW_DEPTH   = 1 << IDX_W;
    localparam int LIM_COL     = (MAX_SRC_WIDTH < ROW_DEPTH) ? MAX_SRC_WIDTH : ROW_DEPTH;
    localparam int LIM_ROW     = (MAX_SRC_HEIGHT < ROW_DEPTH) ? MAX_SRC_HEIGHT : ROW_DEPTH;

    logic                 r_depth_mode;
    logic [8:0]           r_src_w, r_src_h;
    logic [DIVISOR_W-1:0] r_dst_w, r_dst_h;
    logic                 r_div_pend;
    logic                 col_busy, row_busy;
    logic [STEP_W-1:0]    col_step, row_step;
    logic [DIVISOR_W-1:0] n_div_w, n_div_h;
    logic [8:0]           n_lim_c, n_lim_r;
    logic                 cfg_wr, cfg_hit, accept;
    t_geom                geom;
    t_load                load;
    t_req                 req;

    logic [ROW_DEPTH-1:0] r_ver_vld;
    logic                 r_e_vld, r_e_ver_vld;
    logic                 src_we;
    logic [2*IDX_W-1:0]   src_waddr;
    logic [31:0]          s00, s11, s01, s10;
    logic [7:0]           ver_rdata;

    assign busy        = r_div_pend | col_busy | row_busy;
    assign o_cfg_ready = !busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign accept      = start && !busy;

    always_comb begin
        case (t_cfg_index'(i_cfg_index))
            CFG_DEPTH_MODE,
            CFG_SOURCE_WIDTH,
            CFG_SOURCE_HEIGHT,
            CFG_TARGET_WIDTH,
            CFG_TARGET_HEIGHT: cfg_hit = 1'b1;
            default:           cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode <= 1'b1;
            r_src_w      <= 9'd256;
            r_src_h      <= 9'd256;
            r_dst_w      <= 11'd256;
            r_dst_h      <= 11'd256;
            r_div_pend   <= 1'b0;
        end else begin
            r_div_pend <= cfg_wr && cfg_hit;
            if (cfg_wr) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_DEPTH_MODE:    r_depth_mode <= i_cfg_data[0];
                    CFG_SOURCE_WIDTH:  r_src_w      <= i_cfg_data[8:0];
                    CFG_SOURCE_HEIGHT: r_src_h      <= i_cfg_data[8:0];
                    CFG_TARGET_WIDTH:  r_dst_w      <= i_cfg_data;
                    CFG_TARGET_HEIGHT: r_dst_h      <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_div_w = (r_dst_w == '0) ? DIVISOR_W'(1) : r_dst_w;
        n_div_h = (r_dst_h == '0) ? DIVISOR_W'(1) : r_dst_h;

        n_lim_c = (r_src_w == '0) ? 9'd1 : r_src_w;
        if (n_lim_c > 9'(LIM_COL)) begin
            n_lim_c = 9'(LIM_COL);
        end
        n_lim_r = (r_src_h == '0) ? 9'd1 : r_src_h;
        if (n_lim_r > 9'(LIM_ROW)) begin
            n_lim_r = 9'(LIM_ROW);
        end

        geom.col_step = col_step;
        geom.row_step = row_step;
        geom.last_col = IDX_W'(n_lim_c - 9'd1);
        geom.last_row = IDX_W'(n_lim_r - 9'd1);

        load.col     = i_src_col;
        load.row     = i_src_row;
        load.pixel   = i_pixel_in;
        load.version = i_row_version_in;
    end

    tis_divider u_col_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_pend),
        .i_dividend ({r_src_w, 8'd0}),
        .i_divisor  (n_div_w),
        .o_busy     (col_busy),
        .o_quot     (col_step)
    );

    tis_divider u_row_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_pend),
        .i_dividend ({r_src_h, 8'd0}),
        .i_divisor  (n_div_h),
        .o_busy     (row_busy),
        .o_quot     (row_step)
    );

    tis_pos #(
        .TILE_SIZE (TILE_SIZE)
    ) u_pos (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (geom),
        .i_start      (accept),
        .i_mode       (i_mode),
        .i_load       (load),
        .i_tile_col   (i_tile_col),
        .i_tile_row   (i_tile_row),
        .i_offset_col (i_offset_col),
        .i_offset_row (i_offset_row),
        .o_req        (req)
    );

    assign src_we    = req.vld && !req.mode;
    assign src_waddr = {req.ld.row, req.ld.col};

    tis_ram #(.DATA_W(32), .DEPTH(STORE_DEPTH)) u_src00 (
        .i_clk (i_clk), .i_we (src_we), .i_waddr (src_waddr), .i_wdata (req.ld.pixel),
        .i_raddr ({req.r0, req.c0}), .o_rdata (s00)
    );

    tis_ram #(.DATA_W(32), .DEPTH(STORE_DEPTH)) u_src11 (
        .i_clk (i_clk), .i_we (src_we), .i_waddr (src_waddr), .i_wdata (req.ld.pixel),
        .i_raddr ({req.r1, req.c1}), .o_rdata (s11)
    );

    tis_ram #(.DATA_W(32), .DEPTH(STORE_DEPTH)) u_src01 (
        .i_clk (i_clk), .i_we (src_we), .i_waddr (src_waddr), .i_wdata (req.ld.pixel),
        .i_raddr ({req.r0, req.c1}), .o_rdata (s01)
    );

    tis_ram #(.DATA_W(32), .DEPTH(STORE_DEPTH)) u_src10 (
        .i_clk (i_clk), .i_we (src_we), .i_waddr (src_waddr), .i_wdata (req.ld.pixel),
        .i_raddr ({req.r1, req.c0}), .o_rdata (s10)
    );

    tis_ram #(.DATA_W(8), .DEPTH(ROW_DEPTH)) u_ver (
        .i_clk (i_clk), .i_we (src_we), .i_waddr (req.ld.row), .i_wdata (req.ld.version),
        .i_raddr (req.r0), .o_rdata (ver_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ver_vld <= '0;
            r_e_vld   <= 1'b0;
        end else begin
            r_e_vld <= req.vld && req.mode;
            if (src_we) begin
                r_ver_vld[req.ld.row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_ver_vld <= r_ver_vld[req.r0];
    end

    tis_blend u_blend (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (r_e_vld),
        .i_depth_mode (r_depth_mode),
        .i_s00        (s00),
        .i_s11        (s11),
        .i_s01        (s01),
        .i_s10        (s10),
        .i_version    (r_e_ver_vld ? ver_rdata : 8'd0),
        .o_strobe     (o_strobe),
        .o_pixel      (o_pixel_out),
        .o_version    (o_row_version_out)
    );

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && cfg_hit) |=> busy)
        else $error("register write did not hold off new words while steps are derived");

    a_ver_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (r_ver_vld == '0))
        else $error("row version valid bits not cleared by reset");

endmodule

`default_nettype wire
